FILE: rtl/bbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbg_pkg
// shared types and constants of the background map generator
// ----------------------------------------------------------------------------
package bbg_pkg;

  // bus request kinds
  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdLatch = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  // pattern store regions, selected by store address bits 13..12
  localparam logic [1:0] RegionNibble = 2'b00;
  localparam logic [1:0] RegionByteLo = 2'b01;
  localparam logic [1:0] RegionByteHi = 2'b10;
  localparam logic [1:0] RegionTile   = 2'b11;

  localparam int NibbleDepth = 4096;
  localparam int ByteDepth   = 8192;
  localparam int TileDepth   = 4096;

  // one accepted bus request
  typedef struct packed {
    logic        valid;
    logic [1:0]  cmd;
    logic [13:0] addr;
    logic [7:0]  wdata;
  } bus_req_t;

  // tile table lookup handed from the map fetch to the tile fetch
  typedef struct packed {
    logic        valid;
    logic        sel;       // 1 reads the upper half (bb1)
    logic [10:0] tile_adr;
    logic [1:0]  flip;      // map value bits 10..9
  } tile_req_t;

  // formatted bb byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } bb_res_t;

endpackage
`default_nettype wire

FILE: rtl/bbg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbg_ram
// single-port-write, single-port-read ram with registered read (read-first)
// ----------------------------------------------------------------------------
module bbg_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/bbg_map_fetch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbg_map_fetch
// position latches, nibble and byte map rams, tile address build
// ----------------------------------------------------------------------------
module bbg_map_fetch (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire bbg_pkg::bus_req_t  req_i,
  output bbg_pkg::tile_req_t      tile_req_o
);
  import bbg_pkg::*;

  logic [7:0]  p0_q, p1_q;
  logic [12:0] map_adr;
  logic        nib_we, byte_we;
  logic [7:0]  nib_rdata, byte_rdata;
  logic        v1_q, sel1_q, p0b1_q, p1b1_q, nsel1_q;
  logic [3:0]  nibble;
  logic [11:0] map_val;

  // position latches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q <= '0;
      p1_q <= '0;
    end else if (req_i.valid && req_i.cmd == CmdLatch) begin
      if (req_i.addr[0]) begin
        p1_q <= req_i.wdata;
      end else begin
        p0_q <= req_i.wdata;
      end
    end
  end

  assign map_adr = {p1_q[6:1], p0_q[7:1]};

  assign nib_we  = req_i.valid && req_i.cmd == CmdLoad && req_i.addr[13:12] == RegionNibble;
  assign byte_we = req_i.valid && req_i.cmd == CmdLoad &&
                   (req_i.addr[13:12] == RegionByteLo || req_i.addr[13:12] == RegionByteHi);

  bbg_ram #(.Width(8), .Depth(NibbleDepth)) u_nibble_ram (
    .clk_i   (clk_i),
    .we_i    (nib_we),
    .waddr_i (req_i.addr[11:0]),
    .wdata_i (req_i.wdata),
    .re_i    (en_i),
    .raddr_i (map_adr[12:1]),
    .rdata_o (nib_rdata)
  );

  // byte map region starts at 0x1000, so index bit 12 is the inverted addr bit 12
  bbg_ram #(.Width(8), .Depth(ByteDepth)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i ({~req_i.addr[12], req_i.addr[11:0]}),
    .wdata_i (req_i.wdata),
    .re_i    (en_i),
    .raddr_i (map_adr),
    .rdata_o (byte_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= req_i.valid && req_i.cmd == CmdRead;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel1_q  <= req_i.addr[0];
      p0b1_q  <= p0_q[0];
      p1b1_q  <= p1_q[0];
      nsel1_q <= map_adr[0];
    end
  end

  assign nibble  = nsel1_q ? nib_rdata[7:4] : nib_rdata[3:0];
  assign map_val = {nibble, byte_rdata};

  // value bit 10 flips tile address bit 0, bit 9 flips bit 1
  always_comb begin
    tile_req_o.valid    = v1_q;
    tile_req_o.sel      = sel1_q;
    tile_req_o.tile_adr = {map_val[8:0], p1b1_q ^ map_val[9], p0b1_q ^ map_val[10]};
    tile_req_o.flip     = map_val[10:9];
  end

endmodule
`default_nettype wire

FILE: rtl/bbg_tile_fetch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbg_tile_fetch
// tile table ram and bb0/bb1 byte formatting
// ----------------------------------------------------------------------------
module bbg_tile_fetch (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire bbg_pkg::bus_req_t  req_i,
  input  wire bbg_pkg::tile_req_t tile_req_i,
  output bbg_pkg::bb_res_t        res_o
);
  import bbg_pkg::*;

  logic       tile_we;
  logic [7:0] tile_rdata;
  logic       v2_q, sel2_q;
  logic [1:0] flip2_q;

  assign tile_we = req_i.valid && req_i.cmd == CmdLoad && req_i.addr[13:12] == RegionTile;

  // read-first: a later load in the same cycle does not leak into this read
  bbg_ram #(.Width(8), .Depth(TileDepth)) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (req_i.addr[11:0]),
    .wdata_i (req_i.wdata),
    .re_i    (en_i),
    .raddr_i ({tile_req_i.sel, tile_req_i.tile_adr}),
    .rdata_o (tile_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= tile_req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel2_q  <= tile_req_i.sel;
      flip2_q <= tile_req_i.flip;
    end
  end

  // bb0 swaps bits 7 and 6, then xors value bit 9 into bit 7 and bit 10 into bit 6
  always_comb begin
    res_o.valid = v2_q;
    if (sel2_q) begin
      res_o.data = tile_rdata;
    end else begin
      res_o.data = {tile_rdata[6] ^ flip2_q[0], tile_rdata[7] ^ flip2_q[1], tile_rdata[5:0]};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/background_map_rom_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// background_map_rom_generator_top
// background map generator: pattern store, position latches and bb readout
// ----------------------------------------------------------------------------
// The block takes one bus request per cycle on the slave side while the
// master side does not stall, and returns a bb byte on the master side for
// every read request. Each read passes through the two dependent synchronous
// ram reads (nibble and byte map in parallel, then the tile table) and the
// output register. Loads and latch writes take effect at their acceptance
// edge and are seen by any later read. Only backpressure on the master side
// stalls the pipeline. The pattern store keeps its contents across reset;
// reset clears the latches and pipeline.
// ----------------------------------------------------------------------------
module background_map_rom_generator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [13:0] addr, [21:14] wdata, [23:22] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata    // [7:0] read_data
);
  import bbg_pkg::*;

  logic      en;
  bus_req_t  req;
  tile_req_t tile_req;
  bb_res_t   res;
  logic      out_valid_q;
  logic [7:0] out_data_q;

  // whole pipeline moves when the output register is free or being drained
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // request as seen by the stores, only live on an accepting edge
  always_comb begin
    req.valid = s_axis_tvalid && en;
    req.cmd   = s_axis_tuser;
    req.addr  = s_axis_tdata[13:0];
    req.wdata = s_axis_tdata[21:14];
  end

  // stage 1: latches, nibble and byte map lookup
  bbg_map_fetch u_map_fetch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .req_i      (req),
    .tile_req_o (tile_req)
  );

  // stage 2: tile table lookup and bb formatting
  bbg_tile_fetch u_tile_fetch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .req_i      (req),
    .tile_req_i (tile_req),
    .res_o      (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res.valid) begin
      out_data_q <= res.data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
